### hw/rtl/tad_pkg.sv
`timescale 1ns / 1ps
package tad_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_TOUCH_ACCEL = 3'd0;
  localparam logic [2:0] REG_TOUCH_GYRO  = 3'd1;
  localparam logic [2:0] REG_KNOCK_ACCEL = 3'd2;
  localparam logic [2:0] REG_KNOCK_GYRO  = 3'd3;
  localparam logic [2:0] REG_TOUCH_HOLD  = 3'd4;
  localparam logic [2:0] REG_KNOCK_WIN   = 3'd5;
  localparam logic [2:0] REG_MOTION_HOLD = 3'd6;
  localparam logic [2:0] REG_COOLDOWN    = 3'd7;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_TOUCH  = 2'd1;
  localparam logic [1:0] CAUSE_KNOCK  = 2'd2;
  localparam logic [1:0] CAUSE_MOTION = 2'd3;

  localparam logic [3:0]  KNOCKS_REQUIRED = 4'd3;
  localparam logic [3:0]  KNOCK_MAX       = 4'd15;
  localparam logic [31:0] TOUCH_REFIRE_MS = 32'd2000;
  localparam logic [31:0] KNOCK_GAP_MS    = 32'd150;

  localparam logic [15:0] SPEED_STOP_CENTI  = 16'd200;
  localparam logic [15:0] SPEED_MAX_AGE     = 16'd3000;
  localparam logic [13:0] MOTION_ACCEL_MG   = 14'd100;
  localparam logic [15:0] MOTION_GYRO_MILLI = 16'd350;

  typedef struct packed {
    logic [13:0] touch_accel_threshold;
    logic [15:0] touch_gyro_threshold;
    logic [13:0] knock_accel_threshold;
    logic [15:0] knock_gyro_threshold;
    logic [15:0] touch_hold_ms;
    logic [15:0] knock_span_ms;
    logic [15:0] motion_hold_ms;
    logic [19:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [13:0] accel_delta_mg;
    logic [15:0] gyro_mag_milli;
    logic        imu_moving;
    logic        imu_ready;
    logic        is_armed;
    logic        is_locked;
    logic        speed_valid;
    logic [15:0] speed_age_ms;
    logic [15:0] speed_centi_kmph;
  } sample_t;

  typedef struct packed {
    logic       alarm_fired;
    logic [1:0] cause;
    logic       suppressed;
    logic       alarm_latched;
  } result_t;

endpackage

### hw/rtl/tad_sample_if.sv
`timescale 1ns / 1ps
interface tad_sample_if;
  logic             valid;
  logic             ready;
  tad_pkg::sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tad_result_if.sv
`timescale 1ns / 1ps
interface tad_result_if;
  logic             valid;
  logic             ready;
  tad_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tad_cfg_regs.sv
`timescale 1ns / 1ps
module tad_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tad_pkg::ADDR_W-1:0]  paddr,
  input  logic [tad_pkg::DATA_W-1:0]  pwdata,
  output logic [tad_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tad_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_accel_threshold <= 14'd300;
      cfg.touch_gyro_threshold  <= 16'd1000;
      cfg.knock_accel_threshold <= 14'd600;
      cfg.knock_gyro_threshold  <= 16'd2000;
      cfg.touch_hold_ms         <= 16'd1500;
      cfg.knock_span_ms         <= 16'd3000;
      cfg.motion_hold_ms        <= 16'd5000;
      cfg.cooldown_ms           <= 20'd30000;
    end else if (wr_en) begin
      unique case (reg_idx)
        tad_pkg::REG_TOUCH_ACCEL: cfg.touch_accel_threshold <= pwdata[13:0];
        tad_pkg::REG_TOUCH_GYRO:  cfg.touch_gyro_threshold  <= pwdata[15:0];
        tad_pkg::REG_KNOCK_ACCEL: cfg.knock_accel_threshold <= pwdata[13:0];
        tad_pkg::REG_KNOCK_GYRO:  cfg.knock_gyro_threshold  <= pwdata[15:0];
        tad_pkg::REG_TOUCH_HOLD:  cfg.touch_hold_ms         <= pwdata[15:0];
        tad_pkg::REG_KNOCK_WIN:   cfg.knock_span_ms         <= pwdata[15:0];
        tad_pkg::REG_MOTION_HOLD: cfg.motion_hold_ms        <= pwdata[15:0];
        tad_pkg::REG_COOLDOWN:    cfg.cooldown_ms           <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      tad_pkg::REG_TOUCH_ACCEL: prdata = {18'd0, cfg.touch_accel_threshold};
      tad_pkg::REG_TOUCH_GYRO:  prdata = {16'd0, cfg.touch_gyro_threshold};
      tad_pkg::REG_KNOCK_ACCEL: prdata = {18'd0, cfg.knock_accel_threshold};
      tad_pkg::REG_KNOCK_GYRO:  prdata = {16'd0, cfg.knock_gyro_threshold};
      tad_pkg::REG_TOUCH_HOLD:  prdata = {16'd0, cfg.touch_hold_ms};
      tad_pkg::REG_KNOCK_WIN:   prdata = {16'd0, cfg.knock_span_ms};
      tad_pkg::REG_MOTION_HOLD: prdata = {16'd0, cfg.motion_hold_ms};
      tad_pkg::REG_COOLDOWN:    prdata = {12'd0, cfg.cooldown_ms};
      default:                  prdata = '0;
    endcase
  end

endmodule

### hw/rtl/tad_detect.sv
`timescale 1ns / 1ps
module tad_detect (
  input  logic              clk,
  input  logic              rst,
  input  tad_pkg::cfg_t     cfg,
  input  logic              step,
  input  tad_pkg::sample_t  item,
  output tad_pkg::result_t  res
);

  logic [31:0] touch_start, touch_start_next;
  logic [31:0] last_touch_fire, last_touch_fire_next;
  logic [3:0]  knock_count, knock_count_next;
  logic [31:0] first_knock_time, first_knock_time_next;
  logic [31:0] last_knock_time, last_knock_time_next;
  logic [31:0] motion_start, motion_start_next;
  logic [31:0] cooldown_until, cooldown_until_next;
  logic        latched, latched_next;

  logic        go, stop, touch, hit, motion, fired;
  logic [1:0]  cause;
  logic [31:0] now, ts, ms, fkt;
  logic [3:0]  kc;

  always_comb begin
    now   = item.now_ms;
    go    = item.imu_ready && item.is_armed && item.is_locked;
    stop  = item.speed_valid && (item.speed_age_ms <= tad_pkg::SPEED_MAX_AGE)
            && (item.speed_centi_kmph >= tad_pkg::SPEED_STOP_CENTI);
    touch = (item.accel_delta_mg > cfg.touch_accel_threshold)
            || (item.gyro_mag_milli > cfg.touch_gyro_threshold);
    hit   = (item.accel_delta_mg > cfg.knock_accel_threshold)
            || (item.gyro_mag_milli > cfg.knock_gyro_threshold);
    motion = (item.accel_delta_mg > tad_pkg::MOTION_ACCEL_MG)
             || (item.gyro_mag_milli > tad_pkg::MOTION_GYRO_MILLI) || item.imu_moving;

    touch_start_next      = touch_start;
    last_touch_fire_next  = last_touch_fire;
    knock_count_next      = knock_count;
    first_knock_time_next = first_knock_time;
    last_knock_time_next  = last_knock_time;
    motion_start_next     = motion_start;
    cooldown_until_next   = cooldown_until;
    latched_next          = latched;
    cause = tad_pkg::CAUSE_NONE;
    fired = 1'b0;
    ts    = '0;
    ms    = '0;
    fkt   = first_knock_time;
    kc    = knock_count;

    if (go) begin
      if (stop) begin
        knock_count_next  = '0;
        motion_start_next = '0;
        touch_start_next  = '0;
      end else begin
        // touch hold
        if (touch) begin
          ts = (touch_start == '0) ? now : touch_start;
          touch_start_next = ts;
          if ((now - ts) >= {16'd0, cfg.touch_hold_ms}
              && (now - last_touch_fire) >= tad_pkg::TOUCH_REFIRE_MS) begin
            last_touch_fire_next = now;
            touch_start_next     = '0;
            cause                = tad_pkg::CAUSE_TOUCH;
          end
        end else begin
          touch_start_next = '0;
        end

        // debounced knock count
        if (cause == tad_pkg::CAUSE_NONE && hit
            && (now - last_knock_time) >= tad_pkg::KNOCK_GAP_MS) begin
          last_knock_time_next = now;
          if (knock_count == '0) begin
            fkt = now;
          end
          if (knock_count < tad_pkg::KNOCK_MAX) begin
            kc = knock_count + 4'd1;
          end
          if (kc >= tad_pkg::KNOCKS_REQUIRED
              && (now - fkt) <= {16'd0, cfg.knock_span_ms}) begin
            kc    = '0;
            cause = tad_pkg::CAUSE_KNOCK;
          end
        end
        if (cause == tad_pkg::CAUSE_NONE && kc != '0
            && (now - fkt) > {16'd0, cfg.knock_span_ms}) begin
          kc = '0;
        end
        first_knock_time_next = fkt;
        knock_count_next      = kc;

        // sustained motion
        if (cause == tad_pkg::CAUSE_NONE) begin
          if (motion) begin
            ms = (motion_start == '0) ? now : motion_start;
            motion_start_next = ms;
            if ((now - ms) >= {16'd0, cfg.motion_hold_ms}) begin
              motion_start_next = '0;
              cause             = tad_pkg::CAUSE_MOTION;
            end
          end else begin
            motion_start_next = '0;
          end
        end

        if (cause != tad_pkg::CAUSE_NONE && !(now < cooldown_until)) begin
          fired               = 1'b1;
          latched_next        = 1'b1;
          cooldown_until_next = now + {12'd0, cfg.cooldown_ms};
        end
      end
    end

    res.alarm_fired   = fired;
    res.cause         = cause;
    res.suppressed    = (cause != tad_pkg::CAUSE_NONE) && !fired;
    res.alarm_latched = latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_start      <= '0;
      last_touch_fire  <= '0;
      knock_count      <= '0;
      first_knock_time <= '0;
      last_knock_time  <= '0;
      motion_start     <= '0;
      cooldown_until   <= '0;
      latched          <= 1'b0;
    end else if (step) begin
      touch_start      <= touch_start_next;
      last_touch_fire  <= last_touch_fire_next;
      knock_count      <= knock_count_next;
      first_knock_time <= first_knock_time_next;
      last_knock_time  <= last_knock_time_next;
      motion_start     <= motion_start_next;
      cooldown_until   <= cooldown_until_next;
      latched          <= latched_next;
    end
  end

endmodule

### hw/rtl/tamper_alarm_detector_unit.sv
`timescale 1ns / 1ps
// Tamper alarm detector. Each sample item is one evaluation tick and yields exactly one
// result item. An item is captured in an input register, evaluated combinationally
// against the detector state, and its result lands in an output register. A new item
// is taken every cycle while the output register is free, so throughput is one item
// per clock unless the result consumer stalls; with the consumer stalled the block
// holds two items, one in each register, and then stalls its input.
// Configuration registers sit on the APB port at byte address 4*i and should be written
// only while no items are in flight.
module tamper_alarm_detector_unit (
  input  logic                        clk,
  input  logic                        rst,
  tad_sample_if.sink                  sample,
  tad_result_if.source                result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tad_pkg::ADDR_W-1:0]  paddr,
  input  logic [tad_pkg::DATA_W-1:0]  pwdata,
  output logic [tad_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  tad_pkg::cfg_t    cfg;
  tad_pkg::sample_t hold_data;
  tad_pkg::result_t res;
  tad_pkg::result_t out_data;
  logic             hold_valid;
  logic             out_valid;
  logic             out_free;
  logic             advance;

  tad_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tad_detect u_detect (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (hold_data),
    .res  (res)
  );

  assign out_free     = !out_valid || result.ready;
  assign advance      = hold_valid && out_free;
  assign sample.ready = !hold_valid || out_free;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (sample.ready) begin
      hold_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      hold_data <= sample.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

### dv/tb_tamper_alarm_detector_unit.sv
`timescale 1ns / 1ps
module tb_tamper_alarm_detector_unit;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_SHOWN = 10;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned LONG_STALL = 300;

  typedef enum int unsigned {
    SEG_QUIET, SEG_TOUCH, SEG_KNOCK, SEG_MOTION, SEG_DRIVE, SEG_NOISE
  } seg_kind_t;

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [tad_pkg::ADDR_W-1:0] paddr;
  logic [tad_pkg::DATA_W-1:0] pwdata;
  logic [tad_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  tad_sample_if smp ();
  tad_result_if res ();

  tamper_alarm_detector_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // detector state mirror
  tad_pkg::cfg_t cfg_m;
  logic [31:0]   touch_since;
  logic [31:0]   touch_fired_at;
  logic [31:0]   first_knock_at;
  logic [31:0]   last_knock_at;
  logic [31:0]   motion_since;
  logic [31:0]   cooldown_end;
  logic [3:0]    knock_tally;
  logic          alarm_held;

  tad_pkg::result_t verdicts_due [$];
  int unsigned      mismatches;
  int unsigned      snd_idle_pct;
  int unsigned      rcv_idle_pct;
  int unsigned      stall_left;
  int unsigned      cycle_cnt;
  logic [31:0]      clock_ms;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic tad_pkg::cfg_t default_cfg();
    tad_pkg::cfg_t c;
    c.touch_accel_threshold = 14'd300;
    c.touch_gyro_threshold  = 16'd1000;
    c.knock_accel_threshold = 14'd600;
    c.knock_gyro_threshold  = 16'd2000;
    c.touch_hold_ms         = 16'd1500;
    c.knock_span_ms         = 16'd3000;
    c.motion_hold_ms        = 16'd5000;
    c.cooldown_ms           = 20'd30000;
    return c;
  endfunction

  function automatic tad_pkg::cfg_t random_cfg();
    tad_pkg::cfg_t c;
    c.touch_accel_threshold = 14'($urandom_range(16000));
    c.touch_gyro_threshold  = 16'($urandom_range(65535));
    c.knock_accel_threshold = 14'($urandom_range(16000));
    c.knock_gyro_threshold  = 16'($urandom_range(65535));
    c.touch_hold_ms         = 16'($urandom_range(4000));
    c.knock_span_ms         = 16'($urandom_range(65535));
    c.motion_hold_ms        = 16'($urandom_range(8000));
    c.cooldown_ms           = $urandom_range(1) ? 20'($urandom_range(5000))
                                                : 20'($urandom_range(1000000));
    return c;
  endfunction

  function automatic void reset_model();
    cfg_m          = default_cfg();
    touch_since    = '0;
    touch_fired_at = '0;
    first_knock_at = '0;
    last_knock_at  = '0;
    motion_since   = '0;
    cooldown_end   = '0;
    knock_tally    = '0;
    alarm_held     = 1'b0;
  endfunction

  function automatic logic [31:0] reg_image(input tad_pkg::cfg_t c, input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      tad_pkg::REG_TOUCH_ACCEL: v = 32'(c.touch_accel_threshold);
      tad_pkg::REG_TOUCH_GYRO:  v = 32'(c.touch_gyro_threshold);
      tad_pkg::REG_KNOCK_ACCEL: v = 32'(c.knock_accel_threshold);
      tad_pkg::REG_KNOCK_GYRO:  v = 32'(c.knock_gyro_threshold);
      tad_pkg::REG_TOUCH_HOLD:  v = 32'(c.touch_hold_ms);
      tad_pkg::REG_KNOCK_WIN:   v = 32'(c.knock_span_ms);
      tad_pkg::REG_MOTION_HOLD: v = 32'(c.motion_hold_ms);
      tad_pkg::REG_COOLDOWN:    v = 32'(c.cooldown_ms);
      default:                  v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] elapsed_ms(input logic [31:0] now, input logic [31:0] t0);
    return now - t0;
  endfunction

  function automatic tad_pkg::result_t evaluate_tick(input tad_pkg::sample_t s);
    tad_pkg::result_t r;
    logic [1:0]       why;
    logic             touch;
    logic             hit;
    logic             motion;
    logic             fired;
    why = tad_pkg::CAUSE_NONE;
    fired = 1'b0;
    if (s.imu_ready && s.is_armed && s.is_locked) begin
      if (s.speed_valid && s.speed_age_ms <= tad_pkg::SPEED_MAX_AGE &&
          s.speed_centi_kmph >= tad_pkg::SPEED_STOP_CENTI) begin
        knock_tally = '0;
        motion_since = '0;
        touch_since = '0;
      end else begin
        touch = s.accel_delta_mg > cfg_m.touch_accel_threshold ||
                s.gyro_mag_milli > cfg_m.touch_gyro_threshold;
        hit = s.accel_delta_mg > cfg_m.knock_accel_threshold ||
              s.gyro_mag_milli > cfg_m.knock_gyro_threshold;
        motion = s.accel_delta_mg > tad_pkg::MOTION_ACCEL_MG ||
                 s.gyro_mag_milli > tad_pkg::MOTION_GYRO_MILLI || s.imu_moving;
        if (touch) begin
          if (touch_since == '0) touch_since = s.now_ms;
          if (elapsed_ms(s.now_ms, touch_since) >= 32'(cfg_m.touch_hold_ms) &&
              elapsed_ms(s.now_ms, touch_fired_at) >= tad_pkg::TOUCH_REFIRE_MS) begin
            touch_fired_at = s.now_ms;
            touch_since = '0;
            why = tad_pkg::CAUSE_TOUCH;
          end
        end else begin
          touch_since = '0;
        end
        if (why == tad_pkg::CAUSE_NONE && hit &&
            elapsed_ms(s.now_ms, last_knock_at) >= tad_pkg::KNOCK_GAP_MS) begin
          last_knock_at = s.now_ms;
          if (knock_tally == '0) first_knock_at = s.now_ms;
          if (knock_tally < tad_pkg::KNOCK_MAX) knock_tally = knock_tally + 4'd1;
          if (knock_tally >= tad_pkg::KNOCKS_REQUIRED &&
              elapsed_ms(s.now_ms, first_knock_at) <= 32'(cfg_m.knock_span_ms)) begin
            knock_tally = '0;
            why = tad_pkg::CAUSE_KNOCK;
          end
        end
        if (why == tad_pkg::CAUSE_NONE && knock_tally != '0 &&
            elapsed_ms(s.now_ms, first_knock_at) > 32'(cfg_m.knock_span_ms))
          knock_tally = '0;
        if (why == tad_pkg::CAUSE_NONE) begin
          if (motion) begin
            if (motion_since == '0) motion_since = s.now_ms;
            if (elapsed_ms(s.now_ms, motion_since) >= 32'(cfg_m.motion_hold_ms)) begin
              motion_since = '0;
              why = tad_pkg::CAUSE_MOTION;
            end
          end else begin
            motion_since = '0;
          end
        end
        if (why != tad_pkg::CAUSE_NONE && s.now_ms >= cooldown_end) begin
          fired = 1'b1;
          alarm_held = 1'b1;
          cooldown_end = s.now_ms + 32'(cfg_m.cooldown_ms);
        end
      end
    end
    r.alarm_fired   = fired;
    r.cause         = why;
    r.suppressed    = (why != tad_pkg::CAUSE_NONE) && !fired;
    r.alarm_latched = alarm_held;
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
    mismatches++;
    if (mismatches <= MAX_SHOWN)
      $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, act_v, $time);
  endfunction

  function automatic tad_pkg::sample_t armed_tick(input logic [31:0] now,
                                                  input logic [13:0] accel,
                                                  input logic [15:0] gyro,
                                                  input logic moving);
    tad_pkg::sample_t s;
    s = '0;
    s.now_ms = now;
    s.accel_delta_mg = accel;
    s.gyro_mag_milli = gyro;
    s.imu_moving = moving;
    s.imu_ready = 1'b1;
    s.is_armed = 1'b1;
    s.is_locked = 1'b1;
    return s;
  endfunction

  function automatic tad_pkg::sample_t next_tick(input seg_kind_t kind,
                                                 input int unsigned pace);
    tad_pkg::sample_t s;
    logic [127:0]     noise;
    int unsigned      pick;
    pick = $urandom_range(99);
    if (pick == 0) clock_ms = $urandom;
    else if (pick == 1) clock_ms = '0;
    else clock_ms = clock_ms + $urandom_range(pace);
    s.now_ms = clock_ms;
    s.accel_delta_mg = 14'($urandom_range(tad_pkg::MOTION_ACCEL_MG));
    s.gyro_mag_milli = 16'($urandom_range(tad_pkg::MOTION_GYRO_MILLI));
    s.imu_moving = ($urandom_range(9) == 0);
    s.imu_ready = ($urandom_range(19) != 0);
    s.is_armed = ($urandom_range(19) != 0);
    s.is_locked = ($urandom_range(19) != 0);
    s.speed_valid = 1'($urandom_range(1));
    s.speed_age_ms = $urandom_range(1) ? 16'($urandom_range(3100, 2900)) : 16'($urandom);
    s.speed_centi_kmph = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(199));
    case (kind)
      SEG_TOUCH: begin
        if ($urandom_range(9) != 0) begin
          if ($urandom_range(1))
            s.accel_delta_mg = 14'($urandom_range(16000, cfg_m.touch_accel_threshold));
          else
            s.gyro_mag_milli = 16'($urandom_range(65535, cfg_m.touch_gyro_threshold));
        end
      end
      SEG_KNOCK: begin
        if ($urandom_range(1)) begin
          if ($urandom_range(1))
            s.accel_delta_mg = 14'($urandom_range(16000, cfg_m.knock_accel_threshold));
          else
            s.gyro_mag_milli = 16'($urandom_range(65535, cfg_m.knock_gyro_threshold));
        end
      end
      SEG_MOTION: s.imu_moving = ($urandom_range(9) != 0);
      SEG_DRIVE: begin
        s.speed_valid = 1'b1;
        s.speed_centi_kmph = 16'($urandom_range(65535, 150));
        s.accel_delta_mg = 14'($urandom_range(16000));
      end
      SEG_NOISE: begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        s = noise[$bits(tad_pkg::sample_t)-1:0];
        s.now_ms = clock_ms;
        s.accel_delta_mg = 14'($urandom_range(16000));
      end
      default: ;
    endcase
    return s;
  endfunction

  // result checker
  always @(posedge clk) begin : check_results
    tad_pkg::result_t want;
    if (!rst && res.valid && res.ready) begin
      if (verdicts_due.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, 32'(res.data));
      end else begin
        want = verdicts_due.pop_front();
        if (res.data.alarm_fired !== want.alarm_fired)
          note_mismatch("alarm_fired", 32'(want.alarm_fired), 32'(res.data.alarm_fired));
        if (res.data.cause !== want.cause)
          note_mismatch("cause", 32'(want.cause), 32'(res.data.cause));
        if (res.data.suppressed !== want.suppressed)
          note_mismatch("suppressed", 32'(want.suppressed), 32'(res.data.suppressed));
        if (res.data.alarm_latched !== want.alarm_latched)
          note_mismatch("alarm_latched", 32'(want.alarm_latched), 32'(res.data.alarm_latched));
      end
    end
  end

  // result receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_tamper_alarm_detector_unit failed");
    $finish;
  end

  task automatic send_tick(input tad_pkg::sample_t s);
    if ($urandom_range(99) < snd_idle_pct) begin
      smp.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    smp.valid <= 1'b1;
    smp.data <= s;
    do @(posedge clk); while (!smp.ready);
    verdicts_due.push_back(evaluate_tick(s));
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= tad_pkg::ADDR_W'({idx, 2'b00});
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
  endtask

  task automatic program_config(input tad_pkg::cfg_t c, input logic do_write);
    logic [31:0] got;
    if (do_write) begin
      for (int i = 0; i < NUM_REGS; i++) apb_xfer(1'b1, 3'(i), reg_image(c, 3'(i)), got);
      cfg_m = c;
    end
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_xfer(1'b0, 3'(i), '0, got);
      if (got !== reg_image(cfg_m, 3'(i)))
        note_mismatch("register readback", reg_image(cfg_m, 3'(i)), got);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n_items);
    seg_kind_t        kind;
    tad_pkg::sample_t s;
    int unsigned      seg_len;
    int unsigned      pace;
    int unsigned      sent;
    sent = 0;
    while (sent < n_items) begin
      kind = seg_kind_t'($urandom_range(SEG_NOISE));
      seg_len = $urandom_range(40, 8);
      case ($urandom_range(4))
        0: pace = 60;
        1: pace = 4000;
        default: pace = 400;
      endcase
      repeat (seg_len) begin
        if (sent < n_items) begin
          s = next_tick(kind, pace);
          send_tick(s);
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    tad_pkg::sample_t s;
    program_config(cfg_m, 1'b0);
    // touch started at time zero reads as not started
    send_tick(armed_tick(32'd0, 14'd400, 16'd0, 1'b0));
    s = armed_tick(32'd100, 14'd400, 16'd0, 1'b0);
    s.imu_ready = 1'b0;
    send_tick(s);
    s.imu_ready = 1'b1;
    s.is_armed = 1'b0;
    send_tick(s);
    s.is_armed = 1'b1;
    s.is_locked = 1'b0;
    send_tick(s);
    send_tick(armed_tick(32'd1000, 14'd400, 16'd0, 1'b0));
    send_tick(armed_tick(32'd2600, 14'd400, 16'd0, 1'b0));
    // fresh speed at the limit clears detectors
    s = armed_tick(32'd2700, 14'd400, 16'd0, 1'b0);
    s.speed_valid = 1'b1;
    s.speed_age_ms = tad_pkg::SPEED_MAX_AGE;
    s.speed_centi_kmph = tad_pkg::SPEED_STOP_CENTI;
    send_tick(s);
    s = armed_tick(32'd2800, 14'd0, 16'd0, 1'b0);
    s.speed_valid = 1'b1;
    s.speed_age_ms = tad_pkg::SPEED_MAX_AGE + 16'd1;
    s.speed_centi_kmph = '1;
    send_tick(s);
    s = armed_tick(32'd2900, 14'd0, '1, 1'b0);
    s.speed_valid = 1'b1;
    s.speed_centi_kmph = tad_pkg::SPEED_STOP_CENTI - 16'd1;
    send_tick(s);
    // knock inside debounce gap, then third knock under cooldown
    send_tick(armed_tick(32'd3000, 14'd0, 16'd3000, 1'b0));
    send_tick(armed_tick(32'd3100, 14'd0, 16'd3000, 1'b0));
    send_tick(armed_tick(32'd3300, 14'd0, 16'd3000, 1'b0));
    send_tick(armed_tick(32'd40000, 14'd0, 16'd0, 1'b1));
    send_tick(armed_tick(32'd45000, 14'd0, 16'd0, 1'b1));
    // motion hold across time wrap
    send_tick(armed_tick(32'hFFFF_FF00, 14'd101, 16'd0, 1'b0));
    send_tick(armed_tick(32'h0000_1000, 14'd0, 16'd351, 1'b0));
    send_tick(armed_tick(32'h0000_2000, 14'd0, 16'd0, 1'b1));
    send_tick(armed_tick(32'hFFFF_FFFF, 14'd16000, 16'hFFFF, 1'b1));
    s = '1;
    s.accel_delta_mg = 14'd16000;
    send_tick(s);
    send_tick('0);
    // knocks spread past the window
    send_tick(armed_tick(32'd50000, 14'd700, 16'd0, 1'b0));
    send_tick(armed_tick(32'd50100, 14'd0, 16'd0, 1'b0));
    send_tick(armed_tick(32'd50200, 14'd700, 16'd0, 1'b0));
    send_tick(armed_tick(32'd50300, 14'd0, 16'd0, 1'b0));
    send_tick(armed_tick(32'd54000, 14'd700, 16'd0, 1'b0));
    clock_ms = 32'd54000;
  endtask

  task automatic test_random_default();
    run_random(400);
  endtask

  task automatic test_config_sweep();
    tad_pkg::cfg_t c;
    c = '0;
    drain();
    program_config(c, 1'b1);
    run_random(140);
    c.touch_accel_threshold = 14'd16000;
    c.touch_gyro_threshold  = 16'd65535;
    c.knock_accel_threshold = 14'd16000;
    c.knock_gyro_threshold  = 16'd65535;
    c.touch_hold_ms         = 16'd65535;
    c.knock_span_ms         = 16'd65535;
    c.motion_hold_ms        = 16'd65535;
    c.cooldown_ms           = 20'd1000000;
    drain();
    program_config(c, 1'b1);
    run_random(140);
    drain();
    program_config(random_cfg(), 1'b1);
    run_random(140);
  endtask

  task automatic test_backpressure();
    drain();
    program_config(default_cfg(), 1'b1);
    stall_left = LONG_STALL;
    run_random(60);
  endtask

  task automatic test_random_final();
    run_random(200);
    drain();
    program_config(random_cfg(), 1'b1);
    run_random(200);
  endtask

  initial begin
    rst <= 1'b1;
    smp.valid <= 1'b0;
    smp.data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    mismatches = 0;
    stall_left = 0;
    clock_ms = '0;
    snd_idle_pct = 32;
    rcv_idle_pct = 54;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_default();
    snd_idle_pct = 54;
    rcv_idle_pct = 32;
    test_config_sweep();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random_final();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("tb_tamper_alarm_detector_unit passed");
    end else begin
      $display("tb_tamper_alarm_detector_unit failed");
    end
    $finish;
  end

endmodule
